// ===== hw/rtl/khst_pkg.sv =====
package khst_pkg;

	// fixed field widths of the item and result beats
	localparam int OP_W   = 3;
	localparam int KEY_W  = 8;
	localparam int HOLD_W = 16;

	// defaults for the top level parameters
	localparam int NUM_KEYS_DEF   = 256;
	localparam int COUNT_BITS_DEF = 16;

	// entries in the command queue between front and back
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [OP_W-1:0] {
		OP_PRESS     = 3'd0,
		OP_RELEASE   = 3'd1,
		OP_TICK      = 3'd2,
		OP_ANNUL_KEY = 3'd3,
		OP_ANNUL_ALL = 3'd4,
		OP_QUERY     = 3'd5
	} op_t;

	// classified command handed from front to back
	typedef struct packed {
		op_t  op;
		logic key_ok;
	} cmd_t;

endpackage

// ===== hw/rtl/khst_ram.sv =====
module khst_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/khst_front.sv =====
module khst_front #(
	parameter int NUM_KEYS = khst_pkg::NUM_KEYS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  logic [khst_pkg::OP_W-1:0]     op,
	input  logic [khst_pkg::KEY_W-1:0]    key,
	output logic                          cmd_vld,
	output khst_pkg::cmd_t                cmd,
	output logic [$clog2(NUM_KEYS)-1:0]   cmd_idx,
	input  logic                          cmd_pop
);
	import khst_pkg::*;

	localparam int IDX_W = $clog2(NUM_KEYS);
	localparam int CMP_W = ((IDX_W > KEY_W) ? IDX_W : KEY_W) + 1;
	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [CMP_W-1:0] key_wide;
	cmd_t             new_cmd;
	logic [IDX_W-1:0] new_idx;
	logic             push;

	cmd_t             q_cmd [QUEUE_DEPTH];
	logic [IDX_W-1:0] q_idx [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	// classify the incoming beat: range check and op decode
	always_comb begin
		key_wide       = CMP_W'(key);
		new_idx        = key_wide[IDX_W-1:0];
		new_cmd.key_ok = key_wide < CMP_W'(NUM_KEYS);
		unique case (op)
			OP_PRESS:     new_cmd.op = OP_PRESS;
			OP_RELEASE:   new_cmd.op = OP_RELEASE;
			OP_TICK:      new_cmd.op = OP_TICK;
			OP_ANNUL_KEY: new_cmd.op = OP_ANNUL_KEY;
			OP_ANNUL_ALL: new_cmd.op = OP_ANNUL_ALL;
			default:      new_cmd.op = OP_QUERY;
		endcase
	end

	assign item_ready = count_q != CNT_W'(QUEUE_DEPTH);
	assign push       = item_valid && item_ready;
	assign cmd_vld    = count_q != '0;
	assign cmd        = q_cmd[rd_ptr_q];
	assign cmd_idx    = q_idx[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			q_cmd[wr_ptr_q] <= new_cmd;
			q_idx[wr_ptr_q] <= new_idx;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (cmd_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !cmd_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && cmd_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> count_q != '0)
		else $error("command popped from empty queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("command queue overfilled");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !cmd_pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count lost a push");

endmodule

// ===== hw/rtl/khst_back.sv =====
module khst_back #(
	parameter int NUM_KEYS   = khst_pkg::NUM_KEYS_DEF,
	parameter int COUNT_BITS = khst_pkg::COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_vld,
	input  khst_pkg::cmd_t                cmd,
	input  logic [$clog2(NUM_KEYS)-1:0]   cmd_idx,
	output logic                          cmd_pop,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic                          is_down,
	output logic                          just_pressed,
	output logic                          was_released,
	output logic [khst_pkg::HOLD_W-1:0]   hold_frames
);
	import khst_pkg::*;

	localparam int IDX_W = $clog2(NUM_KEYS);
	localparam int SAT_W = (COUNT_BITS > HOLD_W) ? COUNT_BITS : HOLD_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_FLUSH,
		ST_LOOKUP,
		ST_RESPOND
	} state_t;

	state_t                state_q;
	logic [IDX_W-1:0]      idx_q;
	logic [IDX_W-1:0]      key_idx_q;
	logic                  key_ok_q;
	logic                  out_vld_q;
	logic                  is_down_q;
	logic                  just_pressed_q;
	logic                  was_released_q;
	logic [HOLD_W-1:0]     hold_frames_q;

	logic                  sw_vld_s1;
	logic [IDX_W-1:0]      sw_idx_s1;

	logic [NUM_KEYS-1:0]   cnt_vld_q;
	logic [NUM_KEYS-1:0]   pend_press_q;
	logic [NUM_KEYS-1:0]   pend_rel_q;
	logic [NUM_KEYS-1:0]   released_q;

	logic                  ram_re;
	logic [IDX_W-1:0]      ram_raddr;
	logic                  ram_we;
	logic [IDX_W-1:0]      ram_waddr;
	logic [COUNT_BITS-1:0] ram_wdata;
	logic [COUNT_BITS-1:0] ram_rdata;

	logic [COUNT_BITS-1:0] sw_cnt;
	logic [COUNT_BITS-1:0] lk_cnt;
	logic [SAT_W-1:0]      lk_wide;
	logic [HOLD_W-1:0]     lk_hold;
	logic                  out_load;

	khst_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (NUM_KEYS)
	) u_cnt_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign cmd_pop   = (state_q == ST_IDLE) && cmd_vld;
	assign ram_re    = (state_q == ST_SWEEP) || (state_q == ST_LOOKUP);
	assign ram_raddr = (state_q == ST_SWEEP) ? idx_q : key_idx_q;

	// tick update of one entry: release, then count up, then press
	always_comb begin
		sw_cnt = cnt_vld_q[sw_idx_s1] ? ram_rdata : '0;
		if (pend_rel_q[sw_idx_s1]) begin
			sw_cnt = '0;
		end
		if (sw_cnt != '0 && sw_cnt != '1) begin
			sw_cnt = sw_cnt + 1'b1;
		end
		if (pend_press_q[sw_idx_s1]) begin
			sw_cnt = COUNT_BITS'(1);
		end
	end

	assign ram_we    = sw_vld_s1;
	assign ram_waddr = sw_idx_s1;
	assign ram_wdata = sw_cnt;

	// status of the named key, hold count saturated to the field width
	always_comb begin
		lk_cnt  = (key_ok_q && cnt_vld_q[key_idx_q]) ? ram_rdata : '0;
		lk_wide = SAT_W'(lk_cnt);
		lk_hold = (lk_wide > SAT_W'({HOLD_W{1'b1}})) ? '1 : lk_wide[HOLD_W-1:0];
	end

	assign out_load = (state_q == ST_RESPOND) && (!out_vld_q || result_ready);

	// sequencer with the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			idx_q          <= '0;
			key_idx_q      <= '0;
			key_ok_q       <= 1'b0;
			out_vld_q      <= 1'b0;
			is_down_q      <= 1'b0;
			just_pressed_q <= 1'b0;
			was_released_q <= 1'b0;
			hold_frames_q  <= '0;
		end else begin
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (result_ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_vld) begin
						key_idx_q <= cmd_idx;
						key_ok_q  <= cmd.key_ok;
						if (cmd.op == OP_TICK) begin
							idx_q   <= '0;
							state_q <= ST_SWEEP;
						end else begin
							state_q <= ST_LOOKUP;
						end
					end
				end
				ST_SWEEP: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == IDX_W'(NUM_KEYS - 1)) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					state_q <= ST_LOOKUP;
				end
				ST_LOOKUP: begin
					state_q <= ST_RESPOND;
				end
				ST_RESPOND: begin
					if (out_load) begin
						is_down_q      <= lk_cnt != '0;
						just_pressed_q <= lk_cnt == COUNT_BITS'(1);
						was_released_q <= key_ok_q && released_q[key_idx_q];
						hold_frames_q  <= lk_hold;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// write-back stage of the tick sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_vld_s1 <= 1'b0;
			sw_idx_s1 <= '0;
		end else begin
			sw_vld_s1 <= state_q == ST_SWEEP;
			sw_idx_s1 <= idx_q;
		end
	end

	// per-key flags: count valid, pending press and release, released marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_vld_q    <= '0;
			pend_press_q <= '0;
			pend_rel_q   <= '0;
			released_q   <= '0;
		end else begin
			if (cmd_pop) begin
				unique case (cmd.op)
					OP_PRESS: begin
						if (cmd.key_ok) begin
							pend_press_q[cmd_idx] <= 1'b1;
						end
					end
					OP_RELEASE: begin
						if (cmd.key_ok) begin
							pend_rel_q[cmd_idx] <= 1'b1;
						end
					end
					OP_ANNUL_KEY: begin
						if (cmd.key_ok) begin
							cnt_vld_q[cmd_idx] <= 1'b0;
						end
					end
					OP_ANNUL_ALL: begin
						cnt_vld_q    <= '0;
						pend_press_q <= '0;
						pend_rel_q   <= '0;
					end
					default: begin
					end
				endcase
			end
			if (sw_vld_s1) begin
				cnt_vld_q[sw_idx_s1] <= 1'b1;
			end
			if (state_q == ST_FLUSH) begin
				released_q   <= pend_rel_q;
				pend_press_q <= '0;
				pend_rel_q   <= '0;
			end
		end
	end

	assign result_valid = out_vld_q;
	assign is_down      = is_down_q;
	assign just_pressed = just_pressed_q;
	assign was_released = was_released_q;
	assign hold_frames  = hold_frames_q;

	a_ram_no_collide: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> ram_raddr != ram_waddr)
		else $error("count ram read and write hit the same entry");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_vld_q || result_ready))
		else $error("result register overwritten before taken");

	a_sweep_full: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_FLUSH) |-> $past(idx_q) == IDX_W'(NUM_KEYS - 1))
		else $error("tick sweep ended before the last key");

	a_pend_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH) |=> (pend_press_q == '0 && pend_rel_q == '0))
		else $error("pending bits survived a tick");

endmodule

// ===== hw/rtl/key_hold_state_tracker_unit.sv =====
// Per-key hold tracker. Each item beat (op, key) gives exactly one result beat with
// the named key's status after the op. For a frame tick the result follows a sweep
// that reads, updates and writes back one hold count per cycle through the single
// write port of the count memory. A two-entry command queue sits in front of the
// sequencer and the result sits in its own register, so new beats are taken while a
// result waits. Key codes at or above NUM_KEYS leave press, release and annul-key
// without effect and report all-zero status; a tick or annul-all from them still acts
// on every key. Unused op codes act as a query.
module key_hold_state_tracker_unit #(
	parameter int NUM_KEYS   = khst_pkg::NUM_KEYS_DEF,
	parameter int COUNT_BITS = khst_pkg::COUNT_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_ready,
	input  logic [khst_pkg::OP_W-1:0]   op,
	input  logic [khst_pkg::KEY_W-1:0]  key,
	output logic                        result_valid,
	input  logic                        result_ready,
	output logic                        is_down,
	output logic                        just_pressed,
	output logic                        was_released,
	output logic [khst_pkg::HOLD_W-1:0] hold_frames
);
	import khst_pkg::*;

	localparam int IDX_W = $clog2(NUM_KEYS);

	logic             cmd_vld;
	cmd_t             cmd;
	logic [IDX_W-1:0] cmd_idx;
	logic             cmd_pop;

	khst_front #(
		.NUM_KEYS (NUM_KEYS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.op         (op),
		.key        (key),
		.cmd_vld    (cmd_vld),
		.cmd        (cmd),
		.cmd_idx    (cmd_idx),
		.cmd_pop    (cmd_pop)
	);

	khst_back #(
		.NUM_KEYS   (NUM_KEYS),
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_vld      (cmd_vld),
		.cmd          (cmd),
		.cmd_idx      (cmd_idx),
		.cmd_pop      (cmd_pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.is_down      (is_down),
		.just_pressed (just_pressed),
		.was_released (was_released),
		.hold_frames  (hold_frames)
	);

endmodule
